// ===== hw/rtl/csic_pkg.sv =====
// Shared types and constants for the color sort intake controller.
// Used by csic_cfg_regs, csic_core and color_sort_intake_controller.
package csic_pkg;

  // command codes carried in the input tuser
  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_START  = 2'd1,
    CMD_STOP   = 2'd2,
    CMD_RSVD   = 2'd3
  } cmd_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_DETECT_ENABLE  = 3'd0,
    REG_ALLIANCE_BLUE  = 3'd1,
    REG_PROX_REQUIRED  = 3'd2,
    REG_PROX_CUSHION   = 3'd3,
    REG_COLOR_THRESH   = 3'd4,
    REG_CALIB_WINDOW   = 3'd5,
    REG_FLING_TIMEOUT  = 3'd6,
    REG_REVERSE_TICKS  = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CLS_NONE = 2'd0,
    CLS_BLUE = 2'd1,
    CLS_RED  = 2'd2
  } ring_class_e;

  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 10;
  localparam int unsigned InDataW   = 56;
  localparam int unsigned OutDataW  = 24;

  localparam logic [7:0] PROX_REQUIRED_RST = 8'd80;
  localparam logic [7:0] PROX_CUSHION_RST  = 8'd29;
  localparam logic [9:0] COLOR_THRESH_RST  = 10'd64;
  localparam logic [7:0] CALIB_WINDOW_RST  = 8'd10;
  localparam logic [7:0] FLING_TIMEOUT_RST = 8'd50;
  localparam logic [7:0] REVERSE_TICKS_RST = 8'd20;

  localparam logic [7:0]         AMBIENT_PROX_RST = 8'd80;
  localparam logic signed [17:0] AMBIENT_DIFF_RST = -18'sd50;

  localparam logic signed [7:0] DRIVE_FULL      = 8'sd127;
  localparam logic signed [7:0] DRIVE_RED_FLING = 8'sd110;
  localparam logic [7:0]        STOP_REV_TICKS  = 8'd2;
  localparam logic [7:0]        COUNT_MAX       = 8'd255;

  typedef struct packed {
    logic       detect_enable;
    logic       alliance_blue;
    logic [7:0] prox_required;
    logic [7:0] prox_cushion;
    logic [9:0] color_threshold;
    logic [7:0] calib_window;
    logic [7:0] fling_timeout;
    logic [7:0] reverse_ticks;
  } cfg_t;

  typedef struct packed {
    logic        lift_propped;
    logic        button_press;
    logic [7:0]  proximity;
    logic [15:0] blue_level;
    logic [15:0] red_level;
    logic [7:0]  ring_target;
    cmd_e        command;
  } item_t;

  typedef struct packed {
    logic [7:0]        rings_counted;
    logic              counting_active;
    ring_class_e       ring_class;
    logic              wrong_color;
    logic              drive_valid;
    logic signed [7:0] intake_drive;
  } result_t;

endpackage

// ===== hw/rtl/csic_cfg_regs.sv =====
// Configuration register file for the intake controller.
// Depends on csic_pkg for register indexes, reset values and cfg_t.
module csic_cfg_regs import csic_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.detect_enable   <= 1'b0;
      cfg_q.alliance_blue   <= 1'b0;
      cfg_q.prox_required   <= PROX_REQUIRED_RST;
      cfg_q.prox_cushion    <= PROX_CUSHION_RST;
      cfg_q.color_threshold <= COLOR_THRESH_RST;
      cfg_q.calib_window    <= CALIB_WINDOW_RST;
      cfg_q.fling_timeout   <= FLING_TIMEOUT_RST;
      cfg_q.reverse_ticks   <= REVERSE_TICKS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_DETECT_ENABLE: cfg_q.detect_enable   <= cfg_wdata_i[0];
        REG_ALLIANCE_BLUE: cfg_q.alliance_blue   <= cfg_wdata_i[0];
        REG_PROX_REQUIRED: cfg_q.prox_required   <= cfg_wdata_i[7:0];
        REG_PROX_CUSHION:  cfg_q.prox_cushion    <= cfg_wdata_i[7:0];
        REG_COLOR_THRESH:  cfg_q.color_threshold <= cfg_wdata_i[9:0];
        REG_CALIB_WINDOW:  cfg_q.calib_window    <= cfg_wdata_i[7:0];
        REG_FLING_TIMEOUT: cfg_q.fling_timeout   <= cfg_wdata_i[7:0];
        REG_REVERSE_TICKS: cfg_q.reverse_ticks   <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/csic_core.sv =====
// Per-sample update: ambient tracking, classification, fling and count sequencing.
// Holds the controller state; depends on csic_pkg for item, result and config types.
module csic_core import csic_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    step_i,
  input  item_t   item_i,
  output result_t res_o
);

  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_FLING     = 2'd1,
    PH_FLING_REV = 2'd2,
    PH_STOP_REV  = 2'd3
  } phase_e;

  logic [7:0]         amb_prox_q, amb_prox_d;
  logic signed [17:0] amb_diff_q, amb_diff_d;
  logic               filter_q, filter_d;
  logic               seen_q, seen_d;
  logic               count_mode_q, count_mode_d;
  logic [7:0]         seen_cnt_q, seen_cnt_d;
  logic [7:0]         target_q, target_d;
  phase_e             phase_q, phase_d;
  logic [7:0]         ticks_q, ticks_d;
  logic               fling_red_q, fling_red_d;

  logic [7:0]         amb_new;
  logic [7:0]         rise;
  logic signed [17:0] diff;
  logic signed [17:0] amb_diff_new;
  logic signed [17:0] rel;
  logic signed [17:0] thr;
  logic               is_blue, is_red, present, reject, still_there;
  logic [7:0]         cnt_inc;
  result_t            res;

  // datapath shared by the idle and fling branches
  always_comb begin
    amb_new      = (item_i.proximity < amb_prox_q) ? item_i.proximity : amb_prox_q;
    rise         = item_i.proximity - amb_new;
    diff         = $signed({2'b00, item_i.blue_level}) - $signed({2'b00, item_i.red_level});
    amb_diff_new = (rise <= cfg_i.calib_window) ? diff : amb_diff_q;
    rel          = diff - amb_diff_new;
    thr          = $signed({8'd0, cfg_i.color_threshold});
    is_blue      = rel > thr;
    is_red       = rel < -thr;
    present      = rise > cfg_i.prox_required;
    reject       = is_blue ? !cfg_i.alliance_blue : cfg_i.alliance_blue;
    still_there  = {1'b0, item_i.proximity} > ({1'b0, amb_prox_q} + {1'b0, cfg_i.prox_cushion});
    cnt_inc      = (seen_cnt_q != COUNT_MAX) ? seen_cnt_q + 8'd1 : seen_cnt_q;
  end

  always_comb begin
    amb_prox_d   = amb_prox_q;
    amb_diff_d   = amb_diff_q;
    filter_d     = filter_q;
    seen_d       = seen_q;
    count_mode_d = count_mode_q;
    seen_cnt_d   = seen_cnt_q;
    target_d     = target_q;
    phase_d      = phase_q;
    ticks_d      = ticks_q;
    fling_red_d  = fling_red_q;
    res          = '0;

    case (item_i.command)
      CMD_START: begin
        count_mode_d = 1'b1;
        target_d     = item_i.ring_target;
        seen_cnt_d   = 8'd0;
      end
      CMD_STOP: begin
        count_mode_d = 1'b0;
      end
      default: begin
        case (phase_q)
          PH_FLING: begin
            res.drive_valid = 1'b1;
            res.wrong_color = 1'b1;
            if (still_there && ticks_q < cfg_i.fling_timeout) begin
              res.intake_drive = fling_red_q ? DRIVE_RED_FLING : DRIVE_FULL;
              ticks_d          = ticks_q + 8'd1;
            end else begin
              res.intake_drive = -DRIVE_FULL;
              phase_d          = PH_FLING_REV;
              ticks_d          = 8'd1;
            end
          end
          PH_FLING_REV: begin
            res.drive_valid = 1'b1;
            if (ticks_q < cfg_i.reverse_ticks) begin
              res.intake_drive = -DRIVE_FULL;
              res.wrong_color  = 1'b1;
              ticks_d          = ticks_q + 8'd1;
            end else begin
              res.intake_drive = DRIVE_FULL;
              phase_d          = PH_IDLE;
              ticks_d          = 8'd0;
            end
          end
          PH_STOP_REV: begin
            res.drive_valid = 1'b1;
            if (ticks_q < STOP_REV_TICKS) begin
              res.intake_drive = -DRIVE_FULL;
              ticks_d          = ticks_q + 8'd1;
            end else begin
              phase_d = PH_IDLE;
              ticks_d = 8'd0;
            end
          end
          default: begin
            if (!item_i.lift_propped) begin
              amb_prox_d = amb_new;
              amb_diff_d = amb_diff_new;
              if (cfg_i.detect_enable) begin
                if (present && !seen_q) begin
                  if (is_blue || is_red) begin
                    res.ring_class = is_blue ? CLS_BLUE : CLS_RED;
                    if (reject) begin
                      if (filter_q) begin
                        res.intake_drive = DRIVE_FULL;
                        res.drive_valid  = 1'b1;
                        res.wrong_color  = 1'b1;
                        phase_d          = PH_FLING;
                        ticks_d          = 8'd0;
                        fling_red_d      = is_red;
                      end
                    end else if (count_mode_q) begin
                      seen_d     = 1'b1;
                      seen_cnt_d = cnt_inc;
                      // target reached: stop with a short reverse
                      if (cnt_inc >= target_q) begin
                        res.intake_drive = -DRIVE_FULL;
                        res.drive_valid  = 1'b1;
                        phase_d          = PH_STOP_REV;
                        ticks_d          = 8'd1;
                        count_mode_d     = 1'b0;
                      end
                    end
                  end
                end else if (!present) begin
                  seen_d = 1'b0;
                end
              end
              if (item_i.button_press) begin
                filter_d = !filter_q;
              end
            end
          end
        endcase
      end
    endcase

    res.counting_active = count_mode_d;
    res.rings_counted   = seen_cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amb_prox_q   <= AMBIENT_PROX_RST;
      amb_diff_q   <= AMBIENT_DIFF_RST;
      filter_q     <= 1'b0;
      seen_q       <= 1'b0;
      count_mode_q <= 1'b0;
      seen_cnt_q   <= 8'd0;
      target_q     <= 8'd0;
      phase_q      <= PH_IDLE;
      ticks_q      <= 8'd0;
      fling_red_q  <= 1'b0;
    end else if (step_i) begin
      amb_prox_q   <= amb_prox_d;
      amb_diff_q   <= amb_diff_d;
      filter_q     <= filter_d;
      seen_q       <= seen_d;
      count_mode_q <= count_mode_d;
      seen_cnt_q   <= seen_cnt_d;
      target_q     <= target_d;
      phase_q      <= phase_d;
      ticks_q      <= ticks_d;
      fling_red_q  <= fling_red_d;
    end
  end

  assign res_o = res;

endmodule

// ===== hw/rtl/color_sort_intake_controller.sv =====
// Top level of the color sort intake controller: stream ports, input and result registers.
// Depends on csic_pkg, csic_cfg_regs and csic_core.

// One sensor sample or command per beat, one result beat per input beat. The block takes a
// new beat every cycle as long as the result side keeps up: an input register feeds the
// state update in csic_core, whose result lands in an output register, so each beat passes
// through the input register, the update logic and then the output register. Backpressure
// on the result side stalls the input side only once both registers are full. Configuration
// writes take effect on the next cycle and are meant to be issued while no beats are in
// flight.
module color_sort_intake_controller import csic_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // ring_target[7:0], red_level[23:8], blue_level[39:24], proximity[47:40],
  // button_press[48], lift_propped[49], zero fill [55:50]
  input  logic [InDataW-1:0]  s_axis_tdata,
  // command[1:0]
  input  logic [1:0]          s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // intake_drive[7:0], drive_valid[8], wrong_color[9], ring_class[11:10],
  // counting_active[12], rings_counted[20:13], zero fill [23:21]
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t    cfg;
  item_t   item_q;
  logic    in_valid_q;
  result_t res;
  result_t res_q;
  logic    out_valid_q;
  logic    advance;
  logic    in_take;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  csic_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  csic_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (advance),
    .item_i (item_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.command      <= cmd_e'(s_axis_tuser);
      item_q.ring_target  <= s_axis_tdata[7:0];
      item_q.red_level    <= s_axis_tdata[23:8];
      item_q.blue_level   <= s_axis_tdata[39:24];
      item_q.proximity    <= s_axis_tdata[47:40];
      item_q.button_press <= s_axis_tdata[48];
      item_q.lift_propped <= s_axis_tdata[49];
    end
    if (advance) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, res_q};

`ifndef NO_ASSERTIONS
  // input side stalls only when both registers are full and the result is not taken
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled without a full pipeline");

  // an undriven result carries zero power
  a_idle_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[8]) |-> (m_axis_tdata[7:0] == 8'd0))
    else $error("nonzero drive while drive_valid is low");

  // a fling always commands the intake
  a_wrong_drives: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[9]) |-> m_axis_tdata[8])
    else $error("wrong_color without drive_valid");

  // an item that passes through the update produces a result on the next cycle
  a_advance_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> m_axis_tvalid)
    else $error("result register not loaded after update");
`endif

endmodule
